// File: rtl/edpmc_pkg.sv
// edpmc_pkg: types, constants and helpers for the dual pid motor controller
// used by encoder_dual_pid_motor_controller and by its test bench
// no dependencies
package edpmc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int EXT_W      = (COUNT_BITS > 32) ? COUNT_BITS : 33;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int MA_W   = 33;           // multiplier operand a, signed
  localparam int MB_W   = 25;           // multiplier operand b, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 60;           // pid sum, covers the position loop range
  localparam int INT_W  = 25;           // integrals stay within +/- 255 * 65536

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_PERIOD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_VEL_SCALE = 3'd0,
    REG_VEL_KP    = 3'd1,
    REG_VEL_KI    = 3'd2,
    REG_VEL_KD    = 3'd3,
    REG_POS_KP    = 3'd4,
    REG_POS_KI    = 3'd5,
    REG_POS_KD    = 3'd6,
    REG_PWM_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SPEED,
    ST_SPDSAT,
    ST_ERR,
    ST_MI,
    ST_MD,
    ST_MP,
    ST_SUM,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // sign-extend a wrapping count value
  function automatic logic signed [EXT_W-1:0] cnt_ext(input logic [COUNT_BITS-1:0] v);
    return EXT_W'(signed'(v));
  endfunction

  // saturate an extended count value to signed 32 bits
  function automatic logic signed [31:0] sat32_ext(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-32:0] top;
    top = v[EXT_W-1:31];
    if (top == '0 || top == '1) begin
      return v[31:0];
    end
    return v[EXT_W-1] ? S32_MIN : S32_MAX;
  endfunction

endpackage

// File: rtl/edpmc_if.sv
// edpmc channel interfaces: input word and result word, valid/ready handshake
// no dependencies

interface edpmc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        enc_a;
  logic        enc_b;
  logic [31:0] goal_velocity;

  modport source (output valid, op, enc_a, enc_b, goal_velocity, input ready);
  modport sink   (input valid, op, enc_a, enc_b, goal_velocity, output ready);
endinterface

interface edpmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  logic [31:0] velocity;
  logic [7:0]  duty;
  logic        direction;
  logic        position_mode;
  logic        drive_updated;

  modport source (output valid, position, velocity, duty, direction, position_mode,
                  drive_updated, input ready);
  modport sink   (input valid, position, velocity, duty, direction, position_mode,
                  drive_updated, output ready);
endinterface

// File: rtl/encoder_dual_pid_motor_controller.sv
// encoder_dual_pid_motor_controller: encoder counter with velocity and position pid loops
// one shared multiplier and accumulator stepped by a small sequencer
// depends on edpmc_pkg and edpmc_if
// flow: an encoder edge word goes from idle straight to the done state; a control period
//   word steps through delta, speed, spdsat, err, mi, md, mp, sum and clamp before done;
//   done waits while the result side stalls, and a new word is taken only back in idle
// period words use the single 33x25 multiplier four times in sequence
// reset: rst_n synchronous active low; clears count, loop state, drive and gains,
//   sets pwm_limit to 255
module encoder_dual_pid_motor_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  edpmc_in_if.sink                         in_ch,
  edpmc_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [edpmc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [edpmc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [edpmc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import edpmc_pkg::*;

  // configuration registers
  logic [23:0] vel_scale_r;
  logic [15:0] vel_kp_r, vel_ki_r, vel_kd_r;
  logic [15:0] pos_kp_r, pos_ki_r, pos_kd_r;
  logic [7:0]  pwm_limit_r;

  // controller state
  logic [COUNT_BITS-1:0]   count_r, last_count_r, held_r;
  logic signed [31:0]      meas_r;
  logic                    latch_pend_r, hold_act_r;
  logic signed [INT_W-1:0] spd_int_r, hold_int_r;
  logic signed [31:0]      spd_last_r, hold_last_r;
  logic signed [8:0]       drive_r;

  // per-word working registers
  logic                    pos_r;      // goal was zero, position loop
  logic                    upd_r;      // word was a control period
  logic signed [31:0]      goal_r;
  logic signed [31:0]      delta_r;
  logic signed [31:0]      err_r;
  logic signed [32:0]      diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // fsm and output register
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire, load_out;

  // ---------------------------------------------------------------------------
  // configuration port: two-phase write, always ready, reads return the register
  // ---------------------------------------------------------------------------
  logic     cfg_we;
  cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_scale_r <= '0;
      vel_kp_r    <= '0;
      vel_ki_r    <= '0;
      vel_kd_r    <= '0;
      pos_kp_r    <= '0;
      pos_ki_r    <= '0;
      pos_kd_r    <= '0;
      pwm_limit_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_VEL_SCALE: vel_scale_r <= pwdata[23:0];
        REG_VEL_KP:    vel_kp_r    <= pwdata[15:0];
        REG_VEL_KI:    vel_ki_r    <= pwdata[15:0];
        REG_VEL_KD:    vel_kd_r    <= pwdata[15:0];
        REG_POS_KP:    pos_kp_r    <= pwdata[15:0];
        REG_POS_KI:    pos_ki_r    <= pwdata[15:0];
        REG_POS_KD:    pos_kd_r    <= pwdata[15:0];
        REG_PWM_LIMIT: pwm_limit_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_VEL_SCALE: prdata = CFG_DATA_W'(vel_scale_r);
      REG_VEL_KP:    prdata = CFG_DATA_W'(vel_kp_r);
      REG_VEL_KI:    prdata = CFG_DATA_W'(vel_ki_r);
      REG_VEL_KD:    prdata = CFG_DATA_W'(vel_kd_r);
      REG_POS_KP:    prdata = CFG_DATA_W'(pos_kp_r);
      REG_POS_KI:    prdata = CFG_DATA_W'(pos_ki_r);
      REG_POS_KD:    prdata = CFG_DATA_W'(pos_kd_r);
      REG_PWM_LIMIT: prdata = CFG_DATA_W'(pwm_limit_r);
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (op_t'(in_ch.op) == OP_PERIOD) ? ST_DELTA : ST_DONE;
        end
      end
      ST_DELTA:  state_nxt = ST_SPEED;
      ST_SPEED:  state_nxt = ST_SPDSAT;
      ST_SPDSAT: state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_MI;
      ST_MI:     state_nxt = ST_MD;
      ST_MD:     state_nxt = ST_MP;
      ST_MP:     state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_CLAMP;
      ST_CLAMP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    load_out    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign in_fire = in_ch.valid & in_ch.ready;

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier: speed scale, then ki, kd and kp of the active loop
  // ---------------------------------------------------------------------------
  logic [15:0]              g_kp, g_ki, g_kd;
  logic signed [31:0]       last_err;
  logic signed [INT_W-1:0]  integ;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  assign g_kp     = pos_r ? pos_kp_r    : vel_kp_r;
  assign g_ki     = pos_r ? pos_ki_r    : vel_ki_r;
  assign g_kd     = pos_r ? pos_kd_r    : vel_kd_r;
  assign last_err = pos_r ? hold_last_r : spd_last_r;
  assign integ    = pos_r ? hold_int_r  : spd_int_r;

  always_comb begin
    case (state_r)
      ST_SPEED: begin
        mul_a = MA_W'(delta_r);
        mul_b = $signed(MB_W'(vel_scale_r));
      end
      ST_MI: begin
        mul_a = MA_W'(err_r);
        mul_b = $signed(MB_W'(g_ki));
      end
      ST_MD: begin
        mul_a = diff_r;
        mul_b = $signed(MB_W'(g_kd));
      end
      ST_MP: begin
        mul_a = MA_W'(err_r);
        mul_b = $signed(MB_W'(g_kp));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // product scaling: q24.24 floor to q16.16 in the velocity loop,
  // counts times q8.8 up to q16.16 in the position loop
  logic signed [ACC_W-1:0] prod_sc;
  assign prod_sc = pos_r ? {prod_r[ACC_W-9:0], 8'b0}
                         : {{(ACC_W-PROD_W+8){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:8]};

  // symmetric clamp to +/- pwm_limit in q16.16
  logic signed [ACC_W-1:0] lim;
  assign lim = $signed(ACC_W'({pwm_limit_r, 16'b0}));

  function automatic logic signed [ACC_W-1:0] clamp_lim(
    input logic signed [ACC_W-1:0] x,
    input logic signed [ACC_W-1:0] l
  );
    if (x < -l) begin
      return -l;
    end
    if (x > l) begin
      return l;
    end
    return x;
  endfunction

  logic signed [ACC_W-1:0] int_sum, int_new, pwm_full;
  logic signed [INT_W-1:0] pwm;
  logic signed [INT_W:0]   pwm_adj;
  logic signed [INT_W:0]   pwm_sh;

  assign int_sum  = ACC_W'(integ) + prod_sc;
  assign int_new  = clamp_lim(int_sum, lim);
  assign pwm_full = clamp_lim(acc_r, lim);
  assign pwm      = pwm_full[INT_W-1:0];
  // truncate toward zero: bias negative values before the arithmetic shift
  assign pwm_adj  = pwm[INT_W-1] ? ((INT_W+1)'(pwm) + (INT_W+1)'(17'sd65535))
                                 : (INT_W+1)'(pwm);
  assign pwm_sh   = pwm_adj >>> 16;

  // speed and error helpers
  logic signed [31:0] prod_sat;
  logic signed [32:0] verr;
  logic signed [31:0] verr_sat;

  always_comb begin
    if (prod_r[PROD_W-1:31] == '0 || prod_r[PROD_W-1:31] == '1) begin
      prod_sat = prod_r[31:0];
    end else begin
      prod_sat = prod_r[PROD_W-1] ? S32_MIN : S32_MAX;
    end
  end

  assign verr = 33'(goal_r) - 33'(meas_r);
  always_comb begin
    if (verr[32] == verr[31]) begin
      verr_sat = verr[31:0];
    end else begin
      verr_sat = verr[32] ? S32_MIN : S32_MAX;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      last_count_r <= '0;
      held_r       <= '0;
      meas_r       <= '0;
      latch_pend_r <= 1'b0;
      hold_act_r   <= 1'b0;
      spd_int_r    <= '0;
      hold_int_r   <= '0;
      spd_last_r   <= '0;
      hold_last_r  <= '0;
      drive_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // encoder edge: up when both channels agree
          if (in_fire && op_t'(in_ch.op) == OP_EDGE) begin
            if (in_ch.enc_a == in_ch.enc_b) begin
              count_r <= count_r + 1'b1;
            end else begin
              count_r <= count_r - 1'b1;
            end
          end
        end
        ST_DELTA: begin
          last_count_r <= count_r;
        end
        ST_SPDSAT: begin
          meas_r <= prod_sat;
          if (pos_r) begin
            hold_act_r <= 1'b1;
            if (latch_pend_r) begin
              held_r       <= count_r;
              latch_pend_r <= 1'b0;
            end
          end else begin
            hold_act_r   <= 1'b0;
            latch_pend_r <= 1'b1;
          end
        end
        ST_MD: begin
          if (pos_r) begin
            hold_int_r <= int_new[INT_W-1:0];
          end else begin
            spd_int_r  <= int_new[INT_W-1:0];
          end
        end
        ST_MP: begin
          if (pos_r) begin
            hold_last_r <= err_r;
          end else begin
            spd_last_r  <= err_r;
          end
        end
        ST_CLAMP: begin
          drive_r <= pwm_sh[8:0];
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (in_fire) begin
      pos_r  <= (in_ch.goal_velocity == '0);
      upd_r  <= (op_t'(in_ch.op) == OP_PERIOD);
      goal_r <= $signed(in_ch.goal_velocity);
    end
    case (state_r)
      ST_DELTA: delta_r <= sat32_ext(cnt_ext(count_r - last_count_r));
      ST_ERR:   err_r   <= pos_r ? sat32_ext(cnt_ext(held_r - count_r)) : verr_sat;
      ST_MI:    diff_r  <= 33'(err_r) - 33'(last_err);
      ST_MD:    acc_r   <= int_new;                 // clamped integral
      ST_MP:    acc_r   <= acc_r + prod_sc;         // derivative term
      ST_SUM:   acc_r   <= acc_r + prod_sc;         // proportional term
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [8:0] duty_sum;
  assign duty_sum = drive_r[8] ? (drive_r + 9'sd255) : drive_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      // count sign-extended, then cut to the 32-bit result field
      out_ch.position      <= 32'(cnt_ext(count_r));
      out_ch.velocity      <= meas_r;
      out_ch.duty          <= duty_sum[7:0];
      out_ch.direction     <= drive_r[8];
      out_ch.position_mode <= hold_act_r;
      out_ch.drive_updated <= upd_r;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef SYNTHESIS
  // a period word always starts the speed measurement
  a_period_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.op == OP_PERIOD |=> state_r == ST_DELTA)
    else $error("period word did not start the sequencer");

  // a new result only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result valid rose outside the done state");

  // latch request and hold mode exclude each other
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(latch_pend_r && hold_act_r))
    else $error("latch pending while position loop active");

  // the input side is closed while a word is in progress
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while busy");
`endif

endmodule

// File: dv/encoder_dual_pid_motor_controller_test.sv
// encoder_dual_pid_motor_controller_test: self-checking bench for the dual pid motor controller
// drives encoder-edge and control-period words, predicts every result word and compares it
// depends on edpmc_pkg, edpmc_if and encoder_dual_pid_motor_controller
`timescale 1ns / 1ps

module encoder_dual_pid_motor_controller_test;
  import edpmc_pkg::*;

  // cycles without any handshake or register write before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;

  // register sets used by the phases of the run
  typedef enum {
    SET_TUNED,
    SET_FULL,
    SET_STALLED,
    SET_OPEN,
    SET_MIXED
  } setting_t;

  // one input word as sent to the block
  typedef struct packed {
    op_t         op;
    logic        enc_a;
    logic        enc_b;
    logic [31:0] goal;
  } motor_cmd_t;

  // one result word as the block should produce it
  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [7:0]  duty;
    logic        direction;
    logic        position_mode;
    logic        drive_updated;
  } motor_reading_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  edpmc_in_if  in_ch ();
  edpmc_out_if out_ch ();

  encoder_dual_pid_motor_controller uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // words waiting to be sent, and results the block still owes us
  motor_cmd_t     cmd_backlog [$];
  motor_reading_t readings_due [$];

  // local copy of the controller registers, indexed by register code
  longint cfg_val [8];

  // local copy of the controller state
  logic [COUNT_BITS-1:0] m_count = '0;
  logic [COUNT_BITS-1:0] m_count_prev = '0;
  logic [COUNT_BITS-1:0] m_held = '0;
  longint m_speed = 0;
  longint m_spd_int = 0;
  longint m_spd_last = 0;
  longint m_hold_int = 0;
  longint m_hold_last = 0;
  longint m_drive = 0;
  bit     m_latch = 1'b0;
  bit     m_hold = 1'b0;

  // handshake bookkeeping shared between the clocked blocks
  bit             in_took;
  bit             out_took;
  bit             calm;
  int unsigned    in_gap;
  int unsigned    out_stall;
  int unsigned    quiet_cycles;
  int unsigned    mismatches;
  motor_cmd_t     next_cmd;
  motor_cmd_t     seen_cmd;
  motor_reading_t want;

  function automatic longint clamp_to(longint x, longint lim);
    if (x < -lim) return -lim;
    if (x > lim) return lim;
    return x;
  endfunction

  function automatic longint sat32(longint x);
    if (x < longint'(S32_MIN)) return longint'(S32_MIN);
    if (x > longint'(S32_MAX)) return longint'(S32_MAX);
    return x;
  endfunction

  // advance the local controller copy by one word and return the result it gives
  function automatic motor_reading_t advance_controller(motor_cmd_t c);
    motor_reading_t        r;
    logic [COUNT_BITS-1:0] diff;
    longint                lim, goal, delta, pwm, e, d, p, pos_ext;
    r.drive_updated = 1'b0;
    if (c.op == OP_EDGE) begin
      // equal channel levels count up, differing levels count down
      if (c.enc_a == c.enc_b) begin
        m_count = m_count + 1'b1;
      end else begin
        m_count = m_count - 1'b1;
      end
    end else begin
      lim = cfg_val[REG_PWM_LIMIT] * 65536;
      goal = $signed(c.goal);
      diff = m_count - m_count_prev;
      delta = $signed(diff);
      m_count_prev = m_count;
      delta = clamp_to(delta, longint'(1) <<< 38);
      m_speed = sat32(delta * cfg_val[REG_VEL_SCALE]);
      if (goal != 0) begin
        // speed loop, q24.24 products floored back to q16.16
        e = sat32(goal - m_speed);
        m_spd_int = clamp_to(m_spd_int + ((e * cfg_val[REG_VEL_KI]) >>> 8), lim);
        d = ((e - m_spd_last) * cfg_val[REG_VEL_KD]) >>> 8;
        m_spd_last = e;
        p = (e * cfg_val[REG_VEL_KP]) >>> 8;
        pwm = clamp_to(p + m_spd_int + d, lim);
        m_latch = 1'b1;
        m_hold = 1'b0;
      end else begin
        // hold loop, target latched on the first zero goal after a moving one
        if (m_latch) begin
          m_held = m_count;
          m_latch = 1'b0;
        end
        m_hold = 1'b1;
        diff = m_held - m_count;
        e = sat32($signed(diff));
        m_hold_int = clamp_to(m_hold_int + e * cfg_val[REG_POS_KI] * 256, lim);
        d = (e - m_hold_last) * cfg_val[REG_POS_KD] * 256;
        m_hold_last = e;
        p = e * cfg_val[REG_POS_KP] * 256;
        pwm = clamp_to(p + m_hold_int + d, lim);
      end
      // truncate toward zero to the integer drive
      if (pwm >= 0) begin
        m_drive = pwm >>> 16;
      end else begin
        m_drive = -((-pwm) >>> 16);
      end
      r.drive_updated = 1'b1;
    end
    pos_ext = $signed(m_count);
    r.position = pos_ext[31:0];
    r.velocity = m_speed[31:0];
    r.duty = (m_drive < 0) ? 8'(255 + m_drive) : 8'(m_drive);
    r.direction = (m_drive < 0);
    r.position_mode = m_hold;
    return r;
  endfunction

  // mostly short gaps, a few long ones, none at all in calm phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] reg_max(cfg_reg_t which);
    if (which == REG_VEL_SCALE) return 32'h00ff_ffff;
    if (which == REG_PWM_LIMIT) return 32'h0000_00ff;
    return 32'h0000_ffff;
  endfunction

  function automatic logic [31:0] rand_reg_value(cfg_reg_t which);
    logic [31:0] top;
    int unsigned r;
    top = reg_max(which);
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd0;
    if (r < 30) return top;
    if (r < 70) begin
      // values that keep the loops out of permanent saturation
      if (which == REG_VEL_SCALE) return $urandom_range(0, 32'h0003_0000);
      if (which == REG_PWM_LIMIT) return $urandom_range(1, 255);
      return $urandom_range(0, 32'h0000_0600);
    end
    return $urandom & top;
  endfunction

  // nonzero goal: mostly modest speeds, some full-range, some extremes
  function automatic logic [31:0] pick_goal();
    logic [31:0] g;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      g = $urandom_range(1, 32'h0010_0000);
      if ($urandom_range(0, 1)) g = -g;
    end else if (r < 85) begin
      g = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: g = 32'h7fff_ffff;
        1: g = 32'h8000_0000;
        2: g = 32'h0000_0001;
        default: g = 32'hffff_ffff;
      endcase
    end
    if (g == 32'd0) g = 32'd1;
    return g;
  endfunction

  task automatic push_cmd(op_t op, logic a, logic b, logic [31:0] goal);
    motor_cmd_t c;
    c.op = op;
    c.enc_a = a;
    c.enc_b = b;
    c.goal = goal;
    cmd_backlog.push_back(c);
  endtask

  // apb write: setup cycle, access cycle, register taken when pready is high
  task automatic write_reg(cfg_reg_t which, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(int'(which) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_val[which] = longint'(value & reg_max(which));
  endtask

  // write every register according to the chosen set
  task automatic load_settings(setting_t style);
    cfg_reg_t    which;
    logic [31:0] v;
    for (int i = 0; i < 8; i++) begin
      which = cfg_reg_t'(i);
      case (style)
        SET_TUNED: begin
          case (which)
            REG_VEL_SCALE: v = 32'h0001_0000;
            REG_VEL_KP:    v = 32'h0000_0100;
            REG_VEL_KI:    v = 32'h0000_0040;
            REG_VEL_KD:    v = 32'h0000_0020;
            REG_POS_KP:    v = 32'h0000_0200;
            REG_POS_KI:    v = 32'h0000_0010;
            REG_POS_KD:    v = 32'h0000_0080;
            default:       v = 32'd255;
          endcase
        end
        SET_FULL:    v = reg_max(which);
        SET_STALLED: v = (which == REG_PWM_LIMIT) ? 32'd0 : rand_reg_value(which);
        SET_OPEN:    v = (which == REG_PWM_LIMIT) ? rand_reg_value(which) : 32'd0;
        default:     v = rand_reg_value(which);
      endcase
      write_reg(which, v);
    end
  endtask

  // motion profiles: runs of edges in a mostly steady direction, each run closed
  // by a control period; goals stay put for a while, hold segments use a zero goal
  task automatic queue_motion(int unsigned budget);
    int unsigned made, periods, edges;
    bit          toward_up, holding;
    logic        a, b;
    logic [31:0] goal;
    made = 0;
    while (made < budget) begin
      holding = ($urandom_range(0, 9) < 3);
      periods = $urandom_range(1, 6);
      goal = pick_goal();
      for (int k = 0; k < periods; k++) begin
        // an occasional long run drives the measured speed into saturation
        if ($urandom_range(0, 39) == 0) begin
          edges = $urandom_range(130, 260);
        end else begin
          edges = $urandom_range(0, 8);
        end
        toward_up = $urandom_range(0, 1);
        for (int j = 0; j < edges; j++) begin
          a = $urandom_range(0, 1);
          if ($urandom_range(0, 99) < 85) begin
            b = toward_up ? a : !a;
          end else begin
            b = $urandom_range(0, 1);
          end
          push_cmd(OP_EDGE, a, b, $urandom);
        end
        if (!holding && $urandom_range(0, 3) == 0) goal = pick_goal();
        push_cmd(OP_PERIOD, $urandom_range(0, 1), $urandom_range(0, 1),
                 holding ? 32'd0 : goal);
        made += edges + 1;
      end
    end
  endtask

  // sender holds off until every owed result word is back and the block is idle
  task automatic wait_for_quiet();
    while (cmd_backlog.size() != 0 || in_ch.valid || readings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // input driver: a new word goes out once the previous one was taken and its gap ran out
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= next_cmd.op;
        in_ch.enc_a <= next_cmd.enc_a;
        in_ch.enc_b <= next_cmd.enc_b;
        in_ch.goal_velocity <= next_cmd.goal;
        in_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure: a random stall, possibly none, after each taken word
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took && out_stall == 0) out_stall = pick_gap();
      if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_field(string what, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
      mismatches++;
    end
  endtask

  // monitor: predict on every accepted input word, check every accepted result word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_cmd.op = op_t'(in_ch.op);
        seen_cmd.enc_a = in_ch.enc_a;
        seen_cmd.enc_b = in_ch.enc_b;
        seen_cmd.goal = in_ch.goal_velocity;
        readings_due.push_back(advance_controller(seen_cmd));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t ns: result word with nothing expected, position %0h",
                   $time, out_ch.position);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          report_field("position", want.position, out_ch.position);
          report_field("velocity", want.velocity, out_ch.velocity);
          report_field("duty", want.duty, out_ch.duty);
          report_field("direction", want.direction, out_ch.direction);
          report_field("position_mode", want.position_mode, out_ch.position_mode);
          report_field("drive_updated", want.drive_updated, out_ch.drive_updated);
        end
      end
      // watchdog: any handshake or register write counts as progress
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // everything known from time zero
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_EDGE;
    in_ch.enc_a = 1'b0;
    in_ch.enc_b = 1'b0;
    in_ch.goal_velocity = 32'd0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_gap = 0;
    out_stall = 0;
    mismatches = 0;
    calm = 1'b0;
    for (int i = 0; i < 8; i++) cfg_val[i] = 0;
    cfg_val[REG_PWM_LIMIT] = 255;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with moderate gains
    load_settings(SET_TUNED);
    // zero goal before any moving goal: hold target stays at reset, enc bits ignored
    push_cmd(OP_PERIOD, 1'b1, 1'b0, 32'd0);
    // all four channel combinations, goal bits ignored on edges
    push_cmd(OP_EDGE, 1'b0, 1'b0, 32'hffff_ffff);
    push_cmd(OP_EDGE, 1'b1, 1'b1, 32'h8000_0000);
    push_cmd(OP_EDGE, 1'b0, 1'b1, 32'h7fff_ffff);
    push_cmd(OP_EDGE, 1'b1, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b0, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b1, 1'b1, 32'd0);
    push_cmd(OP_PERIOD, 1'b0, 1'b1, 32'd0);
    // goal extremes
    push_cmd(OP_PERIOD, 1'b1, 1'b1, 32'h7fff_ffff);
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'h8000_0000);
    // positive speed against the most negative goal saturates the error
    push_cmd(OP_EDGE, 1'b1, 1'b1, 32'd0);
    push_cmd(OP_EDGE, 1'b0, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b1, 1'b1, 32'd0);
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'h8000_0000);
    push_cmd(OP_EDGE, 1'b1, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b0, 1'b1, 32'd0);
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'h0000_0001);
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'hffff_ffff);
    // goal back to zero latches the hold target, then moves off it
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b0, 1'b0, 32'd0);
    push_cmd(OP_EDGE, 1'b1, 1'b1, 32'd0);
    push_cmd(OP_PERIOD, 1'b1, 1'b1, 32'd0);
    push_cmd(OP_PERIOD, 1'b0, 1'b0, 32'h0001_0000);
    wait_for_quiet();

    // random phases across register sets, some without any idling
    calm = 1'b0;
    load_settings(SET_MIXED);
    queue_motion(250);
    wait_for_quiet();

    calm = 1'b1;
    load_settings(SET_FULL);
    queue_motion(250);
    wait_for_quiet();

    calm = 1'b0;
    load_settings(SET_STALLED);
    queue_motion(200);
    wait_for_quiet();

    load_settings(SET_OPEN);
    queue_motion(150);
    wait_for_quiet();

    load_settings(SET_TUNED);
    queue_motion(300);
    wait_for_quiet();

    load_settings(SET_MIXED);
    queue_motion(250);
    wait_for_quiet();

    calm = 1'b1;
    load_settings(SET_MIXED);
    queue_motion(250);
    wait_for_quiet();

    calm = 1'b0;
    load_settings(SET_MIXED);
    queue_motion(300);
    wait_for_quiet();

    repeat (30) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/edpmc_pkg.sv
rtl/edpmc_if.sv
rtl/encoder_dual_pid_motor_controller.sv
dv/encoder_dual_pid_motor_controller_test.sv
